// ----- rtl/hpsd_pkg.sv -----
`default_nettype none

package hpsd_pkg;

   // Panel geometry
   localparam int CHANNELS        = 10;
   localparam int MODULES_PER_ROW = 2;
   localparam int SCAN_LINES      = 8;
   localparam int LINE_LEN        = MODULES_PER_ROW * 64;
   localparam int STORE_DEPTH     = SCAN_LINES * LINE_LEN;

   // Widths
   localparam int LPOS_W  = $clog2(LINE_LEN);
   localparam int POS_W   = LPOS_W + 1;
   localparam int LINE_W  = $clog2(SCAN_LINES);
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int ENTRY_W = 3 * CHANNELS;
   localparam int RGB_W   = 10;
   localparam int COLOR_W = 3;
   localparam int BRIGHT_W = 3;
   localparam int PWM_W   = 3;

   // Opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SHIFT = 2'd1;
   localparam logic [1:0] OP_PWM   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         pixel_row;
      logic [5:0]         pixel_col;
      logic [COLOR_W-1:0] pixel_color;
   } hpsd_req_type;

   typedef struct packed {
      logic [RGB_W-1:0] red_bits;
      logic [RGB_W-1:0] green_bits;
      logic [RGB_W-1:0] blue_bits;
      logic             shift_pulse;
      logic             latch_pulse;
      logic             row_clock;
      logic             row_data;
      logic             output_disable;
   } hpsd_rsp_type;

   // Masked write into the frame store, one 3-bit lane per channel
   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [CHANNELS-1:0] lane_en;
      logic [COLOR_W-1:0]  data;
   } hpsd_wr_type;

   // What one accepted item leaves for the result stage
   typedef struct packed {
      logic data_step;
      logic latch;
      logic row_data;
      logic blank;
   } hpsd_step_type;

endpackage

`default_nettype wire

// ----- rtl/hpsd_frame_mem.sv -----
`default_nettype none

module hpsd_frame_mem (
   input  wire                          clock,
   input  hpsd_pkg::hpsd_wr_type        wr,
   input  wire                          rd_en,
   input  wire  [hpsd_pkg::ADDR_W-1:0]  rd_addr,
   output logic [hpsd_pkg::ENTRY_W-1:0] rd_data
);
   import hpsd_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // lane-masked write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         for (int n = 0; n < CHANNELS; n++) begin
            if (wr.lane_en[n]) begin
               mem_ff[wr.addr][3*n +: 3] <= wr.data;
            end
         end
      end
   end

   // registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hpsd_scan_ctrl.sv -----
`default_nettype none

module hpsd_scan_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           accept,
   input  hpsd_pkg::hpsd_req_type        req,
   input  wire                           csr_wr_en,
   input  wire  [hpsd_pkg::BRIGHT_W-1:0] csr_wr_data,
   output logic                          clear_busy,
   output hpsd_pkg::hpsd_wr_type         wr,
   output logic                          rd_en,
   output logic [hpsd_pkg::ADDR_W-1:0]   rd_addr,
   output hpsd_pkg::hpsd_step_type       step
);
   import hpsd_pkg::*;

   logic                clearing_ff, clearing_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [PWM_W-1:0]    pwm_ff, pwm_in;
   logic                blank_ff, blank_in;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;

   logic                in_panel;
   logic [ADDR_W-1:0]   wr_addr;

   assign in_panel = (32'(req.pixel_row[7:4]) < CHANNELS) &&
                     (32'(req.pixel_col[5]) < MODULES_PER_ROW);

   // scan line, module, column, upper half
   assign wr_addr = (ADDR_W'(req.pixel_row[2:0]) << LPOS_W)
                  + (ADDR_W'(req.pixel_col[5]) << 6)
                  + ADDR_W'(req.pixel_col[4:0])
                  + (req.pixel_row[3] ? ADDR_W'(0) : ADDR_W'(32));

   assign rd_addr    = (ADDR_W'(line_ff) << LPOS_W) + ADDR_W'(pos_ff[LPOS_W-1:0]);
   assign clear_busy = clearing_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      pos_in      = pos_ff;
      line_in     = line_ff;
      pwm_in      = pwm_ff;
      blank_in    = blank_ff;
      bright_in   = csr_wr_en ? csr_wr_data : bright_ff;
      wr          = '0;
      rd_en       = 1'b0;
      step        = '0;

      if (clearing_ff) begin
         wr.we       = 1'b1;
         wr.addr     = clr_addr_ff;
         wr.lane_en  = '1;
         wr.data     = '0;
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end else if (accept) begin
         case (req.opcode)
            OP_WRITE: begin
               if (in_panel) begin
                  wr.we   = 1'b1;
                  wr.addr = wr_addr;
                  wr.data = req.pixel_color;
                  for (int n = 0; n < CHANNELS; n++) begin
                     wr.lane_en[n] = (req.pixel_row[7:4] == 4'(n));
                  end
               end
            end
            OP_SHIFT: begin
               if (pos_ff < POS_W'(LINE_LEN)) begin
                  rd_en          = 1'b1;
                  pos_in         = pos_ff + POS_W'(1);
                  step.data_step = 1'b1;
               end else begin
                  step.latch    = 1'b1;
                  step.row_data = (line_ff == '0);
                  blank_in      = 1'b1;
                  pos_in        = '0;
                  line_in       = line_ff + LINE_W'(1);
               end
            end
            OP_PWM: begin
               blank_in = (pwm_ff < bright_ff) ? 1'b0 : 1'b1;
               pwm_in   = pwm_ff + PWM_W'(1);
            end
            default: begin
            end
         endcase
      end
      step.blank = blank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         pos_ff      <= '0;
         line_ff     <= '0;
         pwm_ff      <= '0;
         blank_ff    <= 1'b1;
         bright_ff   <= BRIGHT_W'(1);
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         pos_ff      <= pos_in;
         line_ff     <= line_in;
         pwm_ff      <= pwm_in;
         blank_ff    <= blank_in;
         bright_ff   <= bright_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hub75_panel_scan_driver_core.sv -----
`default_nettype none

// HUB75 1/8-scan panel driver core.
// Request channel (req_valid/req_stall/req_payload): one transfer per item,
// opcode write pixel, shift step or pwm tick. Result channel
// (rsp_valid/rsp_stall/rsp_payload): exactly one transfer per item, in order,
// carrying the RGB data bits of all channels and the shift, latch, row clock,
// row data and OE levels for the panel pins.
// CSR port: csr_wr_en/csr_wr_data load the 3-bit brightness at any time.
// Pipeline: an item passes the read stage (frame store read), then the
// output register, which raises rsp_valid. Throughput is one item per cycle
// while neither the store sweep nor a receiver stall holds off requests;
// the frame store takes at most one access per item on its single port pair.
// Reset: the scan counters, pwm counter and OE level return to their reset
// values, brightness goes to 1, and the frame store is swept to black one
// entry per cycle over all STORE_DEPTH (1024 for two modules) entries, with
// req_stall high throughout. CSR writes are taken during the sweep.
// Receiver stall: the output register holds its result; the read stage
// behind it still takes one more item if empty, then holds, and req_stall
// goes high until the result leaves.
module hub75_panel_scan_driver_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  hpsd_pkg::hpsd_req_type        req_payload,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output hpsd_pkg::hpsd_rsp_type        rsp_payload,
   input  wire                           csr_wr_en,
   input  wire  [hpsd_pkg::BRIGHT_W-1:0] csr_wr_data
);
   import hpsd_pkg::*;

   logic               accept;
   logic               clear_busy;
   hpsd_wr_type        wr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   hpsd_step_type      step;

   // read stage: holds the item's step while the frame store read completes
   logic               s1_valid_ff, s1_valid_in;
   hpsd_step_type      s1_step_ff;
   logic               s1_adv;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   hpsd_rsp_type       rsp_payload_ff, rsp_payload_in;

   logic [RGB_W-1:0]   red_g, green_g, blue_g;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clear_busy || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   hpsd_scan_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clear_busy  (clear_busy),
      .wr          (wr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .step        (step)
   );

   hpsd_frame_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // channel n sits at bits 3n..3n+2 of a store entry
   for (genvar ch = 0; ch < RGB_W; ch++) begin : g_gather
      if (ch < CHANNELS) begin : g_used
         assign red_g[ch]   = rd_data[3*ch];
         assign green_g[ch] = rd_data[3*ch+1];
         assign blue_g[ch]  = rd_data[3*ch+2];
      end else begin : g_unused
         assign red_g[ch]   = 1'b0;
         assign green_g[ch] = 1'b0;
         assign blue_g[ch]  = 1'b0;
      end
   end

   always_comb begin
      // read stage fills on any transfer; it only keeps its item when blocked
      s1_valid_in    = accept || (s1_valid_ff && !s1_adv);
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_payload_in                = '0;
            if (s1_step_ff.data_step) begin
               rsp_payload_in.red_bits    = red_g;
               rsp_payload_in.green_bits  = green_g;
               rsp_payload_in.blue_bits   = blue_g;
               rsp_payload_in.shift_pulse = 1'b1;
            end
            rsp_payload_in.latch_pulse    = s1_step_ff.latch;
            rsp_payload_in.row_clock      = s1_step_ff.latch;
            rsp_payload_in.row_data       = s1_step_ff.row_data;
            rsp_payload_in.output_disable = s1_step_ff.blank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_step_ff <= step;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ----- rtl/hpsd_checker.sv -----
`default_nettype none

module hpsd_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_stall,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input hpsd_pkg::hpsd_rsp_type        rsp_payload
);
   import hpsd_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // nothing presented and store sweep holding off requests after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("result presented or request taken right after reset");

   // data and latch steps are exclusive; colors only on data steps
   a_step_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.shift_pulse |->
         rsp_payload.red_bits == '0 && rsp_payload.green_bits == '0 &&
         rsp_payload.blue_bits == '0)
      else $error("color bits outside a shift step");

   a_latch_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.latch_pulse |->
         rsp_payload.row_clock && rsp_payload.output_disable &&
         !rsp_payload.shift_pulse)
      else $error("latch step without row clock and blanking");

   a_row_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.row_data || rsp_payload.row_clock) |->
         rsp_payload.latch_pulse)
      else $error("row select outside a latch step");

endmodule

bind hub75_panel_scan_driver_core hpsd_checker u_hpsd_checker (.*);

`default_nettype wire
